// ===== rtl/core/qwt_pkg.sv =====
package qwt_pkg;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_BARE    = 2'd1;
    localparam logic [1:0] MODE_QUOTED  = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       word_end;
        logic       line_end;
    } t_out;

    // Results of one decoded item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_dec;

    function automatic t_out mk_res(logic valid, logic [7:0] ch, logic wend, logic lend);
        t_out r;
        r.char_valid = valid;
        r.out_char   = ch;
        r.word_end   = wend;
        r.line_end   = lend;
        return r;
    endfunction

endpackage

// ===== rtl/core/qwt_decode.sv =====
module qwt_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qwt_pkg::t_in  i_item,
    input  logic          i_take,
    output qwt_pkg::t_dec o_dec
);

    logic [1:0] r_mode, n_mode;
    logic       r_single, n_single;
    logic       r_bs, n_bs;

    logic [7:0] c;
    logic       eol, sp, quoted;
    logic [7:0] q;

    always_comb begin
        c      = i_item.in_char;
        eol    = i_item.end_of_line | (c == 8'd0);
        sp     = (c inside {8'd32, [8'd9:8'd13]});
        quoted = (r_mode == qwt_pkg::MODE_QUOTED);
        q      = r_single ? qwt_pkg::CH_SQUOTE : qwt_pkg::CH_DQUOTE;

        o_dec       = '0;
        n_mode      = r_mode;
        n_single    = r_single;
        n_bs        = r_bs;

        case (r_mode)
            qwt_pkg::MODE_BARE, qwt_pkg::MODE_QUOTED: begin
                if (r_bs) begin
                    n_bs = 1'b0;
                    if (!eol && (c == qwt_pkg::CH_BSLASH || (quoted && c == q))) begin
                        o_dec.count = 2'd1;
                        o_dec.res0  = qwt_pkg::mk_res(1'b1, c, 1'b0, 1'b0);
                    end else begin
                        // keep the lone backslash, then handle the byte
                        o_dec.count = 2'd2;
                        o_dec.res0  = qwt_pkg::mk_res(1'b1, qwt_pkg::CH_BSLASH, 1'b0, 1'b0);
                        if (eol) begin
                            o_dec.res1 = qwt_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b1);
                            n_mode     = qwt_pkg::MODE_BETWEEN;
                            n_single   = 1'b0;
                        end else if (!quoted && sp) begin
                            o_dec.res1 = qwt_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b0);
                            n_mode     = qwt_pkg::MODE_BETWEEN;
                        end else begin
                            o_dec.res1 = qwt_pkg::mk_res(1'b1, c, 1'b0, 1'b0);
                        end
                    end
                end else if (eol) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = qwt_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b1);
                    n_mode      = qwt_pkg::MODE_BETWEEN;
                    n_single    = 1'b0;
                end else if (c == qwt_pkg::CH_BSLASH) begin
                    n_bs = 1'b1;
                end else if ((quoted && c == q) || (!quoted && sp)) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = qwt_pkg::mk_res(1'b0, 8'd0, 1'b1, 1'b0);
                    n_mode      = qwt_pkg::MODE_BETWEEN;
                end else begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = qwt_pkg::mk_res(1'b1, c, 1'b0, 1'b0);
                end
            end
            default: begin
                if (eol) begin
                    o_dec.count = 2'd1;
                    o_dec.res0  = qwt_pkg::mk_res(1'b0, 8'd0, 1'b0, 1'b1);
                    n_mode      = qwt_pkg::MODE_BETWEEN;
                    n_single    = 1'b0;
                    n_bs        = 1'b0;
                end else if (sp) begin
                    n_mode = r_mode;
                end else if (c == qwt_pkg::CH_DQUOTE || c == qwt_pkg::CH_SQUOTE) begin
                    n_mode   = qwt_pkg::MODE_QUOTED;
                    n_single = (c == qwt_pkg::CH_SQUOTE);
                    n_bs     = 1'b0;
                end else if (c == qwt_pkg::CH_BSLASH) begin
                    n_mode = qwt_pkg::MODE_BARE;
                    n_bs   = 1'b1;
                end else begin
                    n_mode      = qwt_pkg::MODE_BARE;
                    n_bs        = 1'b0;
                    o_dec.count = 2'd1;
                    o_dec.res0  = qwt_pkg::mk_res(1'b1, c, 1'b0, 1'b0);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= qwt_pkg::MODE_BETWEEN;
            r_single <= 1'b0;
            r_bs     <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_single <= n_single;
            r_bs     <= n_bs;
        end
    end

`ifndef SYNTH
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_dec.count != 2'd0
            && (o_dec.res0.line_end || (o_dec.count == 2'd2 && o_dec.res1.line_end)))
        |=> (r_mode == qwt_pkg::MODE_BETWEEN && !r_bs && !r_single))
        else $error("state not cleared after end of line");
`endif

endmodule

// ===== rtl/core/qwt_out_buf.sv =====
module qwt_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qwt_pkg::t_dec i_dec,
    input  logic          i_stall,
    output logic          o_valid,
    output qwt_pkg::t_out o_item,
    output logic [1:0]    o_space
);

    qwt_pkg::t_out r_buf [2];
    qwt_pkg::t_out n_buf [2];
    logic [1:0]    r_cnt, n_cnt;
    logic          pop;
    logic [1:0]    base;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[0];
    assign pop     = o_valid & ~i_stall;
    assign o_space = 2'd2 - r_cnt + {1'b0, pop};

    always_comb begin
        n_buf = r_buf;
        base  = r_cnt - {1'b0, pop};
        // advance the queue on a pop, then append after what is left
        if (pop) begin
            n_buf[0] = r_buf[1];
        end
        if (i_push && i_dec.count != 2'd0) begin
            n_buf[base[0]] = i_dec.res0;
        end
        if (i_push && i_dec.count == 2'd2) begin
            n_buf[1] = i_dec.res1;
        end
        n_cnt = base + (i_push ? i_dec.count : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_dec.count <= o_space))
        else $error("result queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule

// ===== rtl/core/quoted_word_tokenizer.sv =====
// Path: an accepted item waits in the input register and then in the result queue before its first result shows.
// Throughput: one item per cycle while each item yields at most one result and the output
// is not stalled; an item that yields two results holds the single result channel while both drain.
// The rate is set by the two-entry result queue that drains one result per unstalled cycle.
// Reset: synchronous, active low; scan state and all valid flags clear, payloads do not.
module quoted_word_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  qwt_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output qwt_pkg::t_out o_out_item
);

    // Input register: holds one byte until the result queue has room for
    // all the results that byte releases.
    logic          r_in_valid;
    qwt_pkg::t_in  r_in;
    qwt_pkg::t_dec dec;
    logic [1:0]    space;
    logic          move;
    logic          accept;

    // Decode the held byte against the scan state; the state advances
    // only when the byte moves on into the result queue.
    qwt_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_take  (move),
        .o_dec   (dec)
    );

    // Two-entry result queue; space already counts this cycle's pop.
    qwt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (move),
        .i_dec   (dec),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_space (space)
    );

    // Move the byte on only if every result it releases fits.
    assign move       = r_in_valid && (dec.count <= space);
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    // Load the payload on accept; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
    end

`ifndef SYNTH
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !move) |=> (r_in_valid && $stable(r_in)))
        else $error("held item lost while waiting for queue room");
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall raised with empty input register");
`endif

endmodule
